[src/cgpm_pkg.sv]
// Package for the colinear grid point marker: item types, register codes and the line test.
`timescale 1ns / 1ps
package cgpm_pkg;

  localparam int WORD_W        = 32;
  localparam int GRID_SIZE_W   = 11;
  localparam int TOL_W         = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;
  localparam int COORD_W       = 10;
  localparam int FLAG_REMOVED  = 1;
  localparam int TOL_FRAC_BITS = 12;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 11'd1024;
  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_MIN   = 11'd3;
  localparam logic [TOL_W-1:0]       TOL_RESET       = 16'd819;
  localparam logic [29:0]            ERR_BASE        = 30'd100;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 1'd1;

  typedef struct packed {
    logic signed [WORD_W-1:0] grid_word;
    logic                     first_of_grid;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]       point_row;
    logic [COORD_W-1:0]       point_col;
    logic signed [WORD_W-1:0] result_word;
    logic                     was_removed;
  } out_item_t;

  // Three-point line test on words w1, w2 (centre), w3.
  function automatic logic line_inline(input logic [WORD_W-1:0] w1,
                                       input logic [WORD_W-1:0] w2,
                                       input logic [WORD_W-1:0] w3,
                                       input logic [TOL_W-1:0]  tol);
    logic signed [24:0] e1;
    logic signed [24:0] e2;
    logic signed [24:0] e3;
    logic signed [25:0] sum;
    logic signed [25:0] adj;
    logic signed [25:0] half;
    logic signed [25:0] err;
    logic        [25:0] err_mag;
    logic signed [25:0] diff;
    logic        [24:0] diff_mag;
    logic        [40:0] prod;
    logic        [29:0] bound;
    logic               ok;
    e1 = $signed({w1[31], w1[31:8]});
    e2 = $signed({w2[31], w2[31:8]});
    e3 = $signed({w3[31], w3[31:8]});
    sum = {e1[24], e1} + {e3[24], e3};
    // halve toward zero: bump negative sums before the arithmetic shift
    adj = sum + {25'd0, sum[25]};
    half = adj >>> 1;
    err = {e2[24], e2} - half;
    err_mag = err[25] ? 26'(-err) : 26'(err);
    diff = {e3[24], e3} - {e1[24], e1};
    diff_mag = diff[25] ? 25'(-diff) : 25'(diff);
    prod = 41'(tol) * 41'(diff_mag);
    bound = 30'(prod[40:TOL_FRAC_BITS]) + ERR_BASE;
    if (w1[FLAG_REMOVED] || w2[FLAG_REMOVED] || w3[FLAG_REMOVED]) begin
      ok = 1'b0;
    end else if (e2 == 25'sd0) begin
      ok = (e1 == 25'sd0) && (e3 == 25'sd0);
    end else begin
      ok = ({4'd0, err_mag} <= bound);
    end
    return ok;
  endfunction

endpackage

[src/colinear_grid_point_marker_unit.sv]
// Top level of the colinear grid point marker: line stores, 3x3 window and result register.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one grid word per item in raster
//   order; first_of_grid restarts the row and column counters. Output channel
//   (out_valid / out_stall / out_data) delivers one item per interior point, once the
//   point below-right of it has arrived, with the removed flag set when any of the eight
//   lines through it is inline.
//   Configuration: cfg_write with cfg_index / cfg_data writes grid_size or tolerance_q12;
//   write only while the block holds no item.
//   Throughput: one item per cycle while out_stall is low. An accepted item has its line
//   store words read at the accept edge and is decided in the decide stage, which holds it
//   while out_stall holds a result; its result is then registered in the output register.
//   The path from the line store read through the eight parallel slope multipliers to the
//   result register sets the cycle time.
//   Reset clears the counters, the window, the output register and the two configuration
//   registers (grid_size 1024, tolerance_q12 819). The line stores are not cleared; they
//   hold valid data once the first rows of a grid have passed.
//   While out_stall holds a result, the decide stage holds its item only when that item
//   also has a result to deliver, and in_stall rises only then.
module colinear_grid_point_marker_unit #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cgpm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cgpm_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [cgpm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cgpm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cgpm_pkg::*;

  localparam int CW = $clog2(MAX_SIZE);
  localparam int SW = CW + 1;

  // configuration
  logic [GRID_SIZE_W-1:0] grid_size;
  logic [TOL_W-1:0]       tolerance_q12;

  // counters
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [CW-1:0] column_count_next;
  logic [CW-1:0] row_count_next;

  // line stores
  logic [WORD_W-1:0] upper_line  [MAX_SIZE];
  logic [WORD_W-1:0] center_line [MAX_SIZE];
  logic [WORD_W-1:0] upper_rd;
  logic [WORD_W-1:0] center_rd;

  // decide stage
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic [CW-1:0]     s1_c;
  logic [CW-1:0]     s1_r;
  logic              s1_interior;
  logic              s1_fwd;
  logic [WORD_W-1:0] s1_fwd_word;
  logic              s1_done;

  // column whose upper store write is still held in the window centre
  logic          pend_valid;
  logic [CW-1:0] pend_addr;

  // window: a0 a1 / m0 m1 / b0 b1
  logic [WORD_W-1:0] a0, a1, m0, m1, b0, b1;
  logic [WORD_W-1:0] a2;
  logic [WORD_W-1:0] m2;
  logic [WORD_W-1:0] m1_mark;
  logic              hit;
  logic              any_line;

  logic          in_accept;
  logic [SW-1:0] n_size;
  logic [SW-1:0] col_base;
  logic [SW-1:0] row_base;
  logic [SW-1:0] col_cur;
  logic [SW-1:0] row_tmp;
  logic [SW-1:0] row_cur;
  logic [SW-1:0] col_inc;
  logic [SW-1:0] row_inc;
  logic [CW-1:0] c_new;
  logic [CW-1:0] r_new;
  logic          fwd_new;
  logic [WORD_W-1:0] fwd_word_new;

  // ---------------------------------------------------------------------------
  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size     <= GRID_SIZE_RESET;
      tolerance_q12 <= TOL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_SIZE: grid_size     <= cfg_data[GRID_SIZE_W-1:0];
        REG_TOLERANCE: tolerance_q12 <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position of the arriving item and the counters after it
  always_comb begin
    if (32'(grid_size) > 32'(MAX_SIZE)) begin
      n_size = SW'(MAX_SIZE);
    end else if (grid_size < GRID_SIZE_MIN) begin
      n_size = SW'(GRID_SIZE_MIN);
    end else begin
      n_size = SW'(grid_size);
    end
    col_base = in_data.first_of_grid ? '0 : {1'b0, column_count};
    row_base = in_data.first_of_grid ? '0 : {1'b0, row_count};
    if (col_base >= n_size) begin
      col_cur = '0;
      row_tmp = row_base + SW'(1);
    end else begin
      col_cur = col_base;
      row_tmp = row_base;
    end
    row_cur = (row_tmp >= n_size) ? '0 : row_tmp;
    c_new = col_cur[CW-1:0];
    r_new = row_cur[CW-1:0];
    col_inc = col_cur + SW'(1);
    row_inc = row_cur + SW'(1);
    if (col_inc >= n_size) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= n_size) ? '0 : row_inc[CW-1:0];
    end else begin
      column_count_next = col_inc[CW-1:0];
      row_count_next    = r_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  assign s1_done   = s1_valid && (!s1_interior || !out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_done;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Upper store forwarding: the column just decided (its centre word) and the pending
  // column (written this edge, or still held in the window) are not in the store yet.
  always_comb begin
    if (s1_done && (c_new == s1_c)) begin
      fwd_new      = 1'b1;
      fwd_word_new = m2;
    end else if (pend_valid && (c_new == pend_addr)) begin
      fwd_new      = 1'b1;
      fwd_word_new = m1_mark;
    end else begin
      fwd_new      = 1'b0;
      fwd_word_new = m1_mark;
    end
  end

  // line stores, read-first
  always_ff @(posedge clk) begin
    if (in_accept) begin
      center_rd          <= center_line[c_new];
      center_line[c_new] <= in_data.grid_word;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && pend_valid) begin
      upper_line[pend_addr] <= m1_mark;
    end
    if (in_accept) begin
      upper_rd <= upper_line[c_new];
    end
  end

  // ---------------------------------------------------------------------------
  // Decide stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word     <= in_data.grid_word;
      s1_c        <= c_new;
      s1_r        <= r_new;
      s1_interior <= (r_new >= CW'(2)) && (c_new >= CW'(2));
      s1_fwd      <= fwd_new;
      s1_fwd_word <= fwd_word_new;
    end
  end

  assign a2 = s1_fwd ? s1_fwd_word : upper_rd;
  assign m2 = center_rd;

  assign any_line =
      line_inline(m0, m1, m2,      tolerance_q12) ||
      line_inline(a1, m1, b1,      tolerance_q12) ||
      line_inline(a0, m1, s1_word, tolerance_q12) ||
      line_inline(a2, m1, b0,      tolerance_q12) ||
      line_inline(a0, m1, m2,      tolerance_q12) ||
      line_inline(b0, m1, m2,      tolerance_q12) ||
      line_inline(m0, m1, a2,      tolerance_q12) ||
      line_inline(m0, m1, s1_word, tolerance_q12);

  assign hit = s1_valid && s1_interior && any_line;

  always_comb begin
    m1_mark = m1;
    if (hit) begin
      m1_mark[FLAG_REMOVED] = 1'b1;
    end
  end

  // shift the window; the marked centre feeds later windows
  always_ff @(posedge clk) begin
    if (rst) begin
      a0         <= '0;
      a1         <= '0;
      m0         <= '0;
      m1         <= '0;
      b0         <= '0;
      b1         <= '0;
      pend_valid <= 1'b0;
      pend_addr  <= '0;
    end else if (s1_done) begin
      a0         <= a1;
      a1         <= a2;
      m0         <= m1_mark;
      m1         <= m2;
      b0         <= b1;
      b1         <= s1_word;
      pend_valid <= 1'b1;
      pend_addr  <= s1_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_done && s1_interior) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_interior) begin
      out_data.point_row   <= COORD_W'(32'(s1_r) - 32'd1);
      out_data.point_col   <= COORD_W'(32'(s1_c) - 32'd1);
      out_data.result_word <= m1_mark;
      out_data.was_removed <= hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  a_pend_is_left_neighbor: assert property (@(posedge clk) disable iff (rst)
    s1_done && s1_interior |-> pend_valid && (pend_addr == CW'(s1_c - CW'(1))))
    else $error("decided point is not the pending column");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with empty decide stage");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_done && s1_interior |=> out_valid)
    else $error("decided interior item produced no result");

  a_removed_flag_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.was_removed |-> out_data.result_word[FLAG_REMOVED])
    else $error("removed item without flag");

endmodule
